### hw/rtl/binary_to_decimal_ascii_unit_macros.svh
// Assertion macros shared by the checker of the decimal text unit.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define B2DA_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Signal must keep its value in the cycle after the condition.
`define B2DA_ASSERT_HOLD(lbl, clk_sig, rstn_sig, cond, sig, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

### hw/rtl/b2da_pkg.sv
// Shared constants for the binary to decimal ASCII text unit.
`timescale 1ns / 1ps

package b2da_pkg;

    // Input value width in use; the sign is the top bit of this width
    localparam int VALUE_WIDTH = 64;
    localparam int IN_W        = 64;

    // Magnitude bits fed through the converter (sign excluded)
    localparam int MAG_W       = VALUE_WIDTH - 1;

    // Decimal digits of 2^MAG_W, an upper bound on the digits of any magnitude
    localparam int DIGITS      = ((MAG_W * 1233) >> 12) + 1;
    localparam int BCD_W       = DIGITS * 4;

    // Counter widths
    localparam int CNT_W       = $clog2(DIGITS + 1);
    localparam int BIT_CNT_W   = (MAG_W > 1) ? $clog2(MAG_W) : 1;

    // Character codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_N    = 8'h6E;
    localparam logic [7:0] CHAR_E    = 8'h65;
    localparam logic [7:0] CHAR_G    = 8'h67;

endpackage

### hw/rtl/binary_to_decimal_ascii_unit.sv
// Top level: signed binary value to decimal ASCII text, bit-serial double dabble.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_stall/value) takes one signed value per request.
//   Output channel (out_valid/out_stall/text_char/last_char) sends one ASCII
//   character per request, most significant digit first, last_char on the final
//   one. Negative values send "neg"; zero sends "0".
// Sequence:
//   A non-negative value is shifted through the shared add-3/shift stage one
//   magnitude bit at a time, then leading zero digits are dropped (keeping at
//   least one), then the characters are sent one by one. A negative value sends
//   "neg" at once. in_stall stays high from acceptance until the last character
//   is loaded.
// Reset:
//   rst_n clears the sequencer and the output valid; nothing else is reset.
// Stall:
//   While out_stall is high with a character valid, the output register holds it
//   and the sequencer waits to send; no character is dropped or repeated.
//
module binary_to_decimal_ascii_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_char,
    output logic        last_char
);

    localparam int MAG_W     = b2da_pkg::MAG_W;
    localparam int DIGITS    = b2da_pkg::DIGITS;
    localparam int BCD_W     = b2da_pkg::BCD_W;
    localparam int CNT_W     = b2da_pkg::CNT_W;
    localparam int BIT_CNT_W = b2da_pkg::BIT_CNT_W;

    localparam logic [CNT_W-1:0]     CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]     CNT_TWO    = CNT_W'(2);
    localparam logic [CNT_W-1:0]     CNT_THREE  = CNT_W'(3);
    localparam logic [CNT_W-1:0]     CNT_DIGITS = CNT_W'(DIGITS);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(MAG_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAG_W-1:0]       bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             text_char_reg, text_char_next;
    logic                   last_char_reg, last_char_next;

    logic                   in_take;
    logic                   out_free;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic [7:0]             cur_char;

    // Add 3 to every BCD digit of 5 or more (digits are independent)
    function automatic logic [BCD_W-1:0] add3_all(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*4 +: 4] >= 4'd5) begin
                res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign bcd_adj   = add3_all(bcd_reg);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Character for the current position
    always_comb
    begin
        if (neg_reg) begin
            case (dig_cnt_reg)
                CNT_THREE: cur_char = b2da_pkg::CHAR_N;
                CNT_TWO:   cur_char = b2da_pkg::CHAR_E;
                default:   cur_char = b2da_pkg::CHAR_G;
            endcase
        end else begin
            cur_char = b2da_pkg::CHAR_ZERO + {4'd0, top_digit};
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take) begin
                    bin_next     = value[MAG_W-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    neg_next     = value[b2da_pkg::VALUE_WIDTH-1];
                    if (value[b2da_pkg::VALUE_WIDTH-1]) begin
                        dig_cnt_next = CNT_THREE;
                        state_next   = ST_EMIT;
                    end else begin
                        state_next   = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                // One magnitude bit per cycle into the BCD register
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST) begin
                    dig_cnt_next = CNT_DIGITS;
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, keeping at least one
                if (top_digit == 4'd0 && dig_cnt_reg != CNT_ONE) begin
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    text_char_next = cur_char;
                    last_char_next = (dig_cnt_reg == CNT_ONE);
                    bcd_next       = bcd_reg << 4;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == CNT_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        bit_cnt_reg   <= bit_cnt_next;
        dig_cnt_reg   <= dig_cnt_next;
        neg_reg       <= neg_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

endmodule

### hw/rtl/b2da_checker.sv
// Port-level checker for the decimal text unit, bound to the top level.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_unit_macros.svh"

module b2da_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  text_char,
    input logic        last_char
);

    logic in_take;
    logic out_held;
    logic is_digit;
    logic is_mid;
    logic is_fin;

    // Handshake and character classes seen on the ports
    assign in_take  = in_valid && !in_stall;
    assign out_held = out_valid && out_stall;
    assign is_digit = (text_char >= b2da_pkg::CHAR_ZERO) &&
                      (text_char <= b2da_pkg::CHAR_NINE);
    assign is_mid   = is_digit || (text_char == b2da_pkg::CHAR_N) ||
                      (text_char == b2da_pkg::CHAR_E);
    assign is_fin   = is_digit || (text_char == b2da_pkg::CHAR_G);

    // A stalled character holds
    `B2DA_ASSERT_HOLD(a_out_hold, clk, rst_n, out_held, text_char, "stalled char changed")

    // The unit is busy right after taking a request
    `B2DA_ASSERT(a_busy_after_take, clk, rst_n, in_take |=> in_stall, "two requests back to back")

    // Non-final characters are digits or part of "neg"
    `B2DA_ASSERT(a_mid_char, clk, rst_n, out_valid && !last_char |-> is_mid, "bad inner char")

    // Final character is a digit or the g of "neg"
    `B2DA_ASSERT(a_last_char, clk, rst_n, out_valid && last_char |-> is_fin, "bad final char")

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);

### sim/binary_to_decimal_ascii_unit_tb.sv
// Testbench for binary_to_decimal_ascii_unit: predicted decimal text checked per character.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_tb;

    // One expected character of the decimal text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  text_char;
    logic        last_char;

    text_char_t  expected_text_q[$];
    int          error_count;
    bit          sender_idle_on;
    bit          receiver_idle_on;
    int          hold_off_cycles;

    binary_to_decimal_ascii_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Queue the characters one value is expected to produce
    function automatic void predict_text(input logic [63:0] raw);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [7:0]  digit_buf[20];
        int          n;
        text_char_t  c;

        mask = {64{1'b1}} >> (64 - b2da_pkg::VALUE_WIDTH);
        mag  = raw & mask;
        n    = 0;

        // Sign bit set: "neg", no digits, most negative value included
        if (mag[b2da_pkg::VALUE_WIDTH-1])
        begin
            c.ch = b2da_pkg::CHAR_N; c.last = 1'b0; expected_text_q.push_back(c);
            c.ch = b2da_pkg::CHAR_E; c.last = 1'b0; expected_text_q.push_back(c);
            c.ch = b2da_pkg::CHAR_G; c.last = 1'b1; expected_text_q.push_back(c);
            return;
        end

        if (mag == 64'd0)
        begin
            c.ch = b2da_pkg::CHAR_ZERO; c.last = 1'b1; expected_text_q.push_back(c);
            return;
        end

        // Digits come out least significant first; send them reversed
        while (mag != 64'd0)
        begin
            digit_buf[n] = b2da_pkg::CHAR_ZERO + 8'(mag % 64'd10);
            mag = mag / 64'd10;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            c.ch   = digit_buf[k];
            c.last = (k == 0);
            expected_text_q.push_back(c);
        end
    endfunction

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // Random value, shaped to spread the digit count over its whole range
    function automatic logic [63:0] random_value();
        logic [63:0] full;
        logic [63:0] v;
        int          bits;

        full = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = full;
            1: v = full | (64'd1 << 63);
            2:
            begin
                bits = $urandom_range(1, 63);
                v = full & ((64'd1 << bits) - 64'd1);
            end
            3: v = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
            4: v = 64'($urandom_range(0, 999));
            default: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
        endcase
        return v;
    endfunction

    // Offer one request and wait until it is taken
    task automatic send_value(input logic [63:0] v);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        predict_text(v);
    endtask

    // Receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (receiver_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted character with the oldest expectation
    always @(posedge clk)
    begin : text_check
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          text_char, last_char));
            end
            else
            begin
                want = expected_text_q.pop_front();
                if (text_char !== want.ch)
                    report_mismatch($sformatf("text_char 0x%02h, want 0x%02h",
                                              text_char, want.ch));
                if (last_char !== want.last)
                    report_mismatch($sformatf("last_char %0b, want %0b on 0x%02h",
                                              last_char, want.last, want.ch));
            end
        end
    end

    // Field extremes, zero, negatives and digit-count boundaries
    task automatic test_directed_values();
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h7FFF_FFFF_FFFF_FFFE);
        send_value(pow10(18) - 64'd1);
        send_value(pow10(18));
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h0000_0000_FFFF_FFFF);
        send_value(64'hFFFF_FFFF_0000_0000);
        // Bits above the value width only matter when it is below 64
        send_value(64'h8000_0000_0000_0001);
        send_value(64'd1 << (b2da_pkg::VALUE_WIDTH - 1));
        send_value((64'd1 << (b2da_pkg::VALUE_WIDTH - 1)) - 64'd1);
    endtask

    task automatic test_random_values(input int count);
        repeat (count) send_value(random_value());
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_hold(input int count);
        hold_off_cycles = 400;
        repeat (count) send_value(random_value());
    endtask

    // Closing stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (count) send_value(random_value());
    endtask

    initial
    begin
        error_count      = 0;
        hold_off_cycles  = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= 64'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values(240);
        test_output_hold(20);
        test_back_to_back(80);
        in_valid <= 1'b0;

        // Drain, then allow for anything extra the block might still send
        while (expected_text_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
